// File: hw/rtl/srg_pkg.sv
// Package for the sprite clip row generator: shared widths, defaults,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package srg_pkg;

    localparam int DefMaxSpriteHeight = 64;
    localparam int DefMaxSpriteWidth  = 256;

    localparam int CfgW     = 11;
    localparam int AddrW    = 20;
    localparam int OffW     = 14;
    localparam int SprWW    = 9;
    localparam int SprHW    = 7;
    localparam int CoordW   = 14;
    localparam int ScrMax   = 1024;
    localparam int SDataW   = 56;
    localparam int MDataW   = 48;
    localparam int PAddrW   = 3;

    localparam logic [CfgW-1:0] ResetScreenWidth  = 11'd320;
    localparam logic [CfgW-1:0] ResetScreenHeight = 11'd240;

    // Register indexes, taken from paddr[2].
    localparam logic RegScreenWidth  = 1'b0;
    localparam logic RegScreenHeight = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SETUP,
        ST_ROWS
    } state_t;

    typedef struct packed {
        logic load;
        logic clip;
        logic setup;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic visible;
        logic last_row;
        logic out_free;
    } status_t;

    function automatic logic [CfgW-1:0] clamp_screen(input logic [CfgW-1:0] v);
        logic [CfgW-1:0] r;
        r = v;
        if (v == '0) begin
            r = 11'd1;
        end else if (v > CfgW'(ScrMax)) begin
            r = CfgW'(ScrMax);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/sprite_clip_row_generator.sv
// Top level of the sprite clip row generator: configuration registers on an
// APB-style port, controller and datapath. Depends on srg_pkg, srg_ctrl, srg_dp.
//
//   Channel   Direction  Word
//   s_*       in         one sprite draw request
//   m_*       out        one visible row descriptor, tlast on the last row
//   APB       in/out     screen_width at 0x0, screen_height at 0x4
//
// A request passes through accept, clip and setup, then the row walk in the
// datapath gives one visible row per cycle unless m_tready stalls.
// A fully clipped request passes accept, clip and setup and gives no word.
// Reset is synchronous on aresetn low; configuration returns to 320 x 240.
// A stall on m_tready holds the row walk; a new request is taken once the
// last row sits in the output register.
module sprite_clip_row_generator #(
    parameter int MAX_SPRITE_HEIGHT = srg_pkg::DefMaxSpriteHeight,
    parameter int MAX_SPRITE_WIDTH  = srg_pkg::DefMaxSpriteWidth
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pos_x[11:0], pos_y[23:12], ref_x[31:24], ref_y[37:32],
    // sprite_width[46:38], sprite_height[53:47], zero fill
    input  logic [srg_pkg::SDataW-1:0]  s_tdata,
    input  logic                        s_tuser,   // shadow_mode
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // screen_address[19:0], sprite_offset[33:20], quad_count[40:34],
    // tail_count[42:41], zero fill
    output logic [srg_pkg::MDataW-1:0]  m_tdata,
    output logic                        m_tuser,   // shadow_out
    output logic                        m_tlast,   // last_row
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srg_pkg::PAddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [srg_pkg::CfgW-1:0] screen_width_reg, screen_height_reg;
    logic                     cfg_wr;
    srg_pkg::cmd_t            cmd;
    srg_pkg::status_t         status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= srg_pkg::ResetScreenWidth;
            screen_height_reg <= srg_pkg::ResetScreenHeight;
        end else if (cfg_wr) begin
            case (paddr[2])
                srg_pkg::RegScreenWidth:  screen_width_reg  <= pwdata[srg_pkg::CfgW-1:0];
                srg_pkg::RegScreenHeight: screen_height_reg <= pwdata[srg_pkg::CfgW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            srg_pkg::RegScreenWidth:  prdata = {21'b0, screen_width_reg};
            srg_pkg::RegScreenHeight: prdata = {21'b0, screen_height_reg};
            default:                  prdata = '0;
        endcase
    end

    srg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    srg_dp #(
        .MAX_SPRITE_HEIGHT (MAX_SPRITE_HEIGHT),
        .MAX_SPRITE_WIDTH  (MAX_SPRITE_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

// File: hw/rtl/srg_ctrl.sv
// Controller state machine of the sprite clip row generator.
// Sequences load, clip, setup and the row walk. Depends on srg_pkg.
module srg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  srg_pkg::status_t  status,
    output srg_pkg::cmd_t     cmd
);

    srg_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srg_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = srg_pkg::ST_CLIP;
            end
            srg_pkg::ST_CLIP: begin
                state_next = srg_pkg::ST_SETUP;
            end
            srg_pkg::ST_SETUP: begin
                state_next = status.visible ? srg_pkg::ST_ROWS : srg_pkg::ST_IDLE;
            end
            srg_pkg::ST_ROWS: begin
                if (status.out_free && status.last_row) state_next = srg_pkg::ST_IDLE;
            end
            default: begin
                state_next = srg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            srg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            srg_pkg::ST_CLIP: begin
                cmd.clip = 1'b1;
            end
            srg_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            srg_pkg::ST_ROWS: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // A row is only written into the output register during the row walk.
    a_emit_in_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> state_reg == srg_pkg::ST_ROWS)
        else $error("row emitted outside the row walk");

    // The last row ends the walk.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && status.last_row) |=> state_reg == srg_pkg::ST_IDLE)
        else $error("walk continued past the last row");

    // A clipped-away sprite never enters the row walk.
    a_clipped_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srg_pkg::ST_SETUP && !status.visible) |=> state_reg == srg_pkg::ST_IDLE)
        else $error("invisible sprite entered the row walk");

endmodule

// File: hw/rtl/srg_dp.sv
// Datapath of the sprite clip row generator: request registers, clipping,
// start address/offset products, row walk counters and the output register.
// Depends on srg_pkg.
module srg_dp #(
    parameter int MAX_SPRITE_HEIGHT = srg_pkg::DefMaxSpriteHeight,
    parameter int MAX_SPRITE_WIDTH  = srg_pkg::DefMaxSpriteWidth
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  srg_pkg::cmd_t               cmd,
    output srg_pkg::status_t            status,
    input  logic [srg_pkg::SDataW-1:0]  s_tdata,
    input  logic                        s_tuser,
    input  logic [srg_pkg::CfgW-1:0]    screen_width,
    input  logic [srg_pkg::CfgW-1:0]    screen_height,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [srg_pkg::MDataW-1:0]  m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int CW = srg_pkg::CoordW;

    // Request registers.
    logic signed [11:0]              pos_x_reg, pos_y_reg;
    logic [7:0]                      ref_x_reg;
    logic [5:0]                      ref_y_reg;
    logic [srg_pkg::SprWW-1:0]       spr_w_reg;
    logic [srg_pkg::SprHW-1:0]       spr_h_reg;
    logic                            shadow_reg;

    // Clip results.
    logic                            visible_reg;
    logic [9:0]                      x0_reg, y0_reg;
    logic [srg_pkg::SprWW-1:0]       sx0_reg;
    logic [5:0]                      sy0_reg;
    logic [srg_pkg::SprWW-1:0]       latched_span_reg;
    logic [srg_pkg::SprHW-1:0]       rows_left_reg;

    // Row walk.
    logic [srg_pkg::AddrW-1:0]       row_screen_address_reg;
    logic [srg_pkg::OffW-1:0]        row_sprite_offset_reg;

    // Output register.
    logic                            m_valid_reg;
    logic [srg_pkg::MDataW-1:0]      m_data_reg;
    logic                            m_user_reg, m_last_reg;

    logic [srg_pkg::CfgW-1:0]        sw_c, sh_c;
    logic [srg_pkg::SprWW-1:0]       w_in;
    logic [srg_pkg::SprHW-1:0]       h_in;
    logic signed [CW-1:0]            xmin, xmax, ymin, ymax;
    logic signed [CW-1:0]            sx0, sx1, sy0, sy1, sw_m1, sh_m1, w_s, h_s;
    logic signed [CW-1:0]            span_s, rows_s;
    logic                            vis_c;
    logic [srg_pkg::AddrW:0]         addr_prod;
    logic [srg_pkg::OffW:0]          off_prod;

    assign sw_c = srg_pkg::clamp_screen(screen_width);
    assign sh_c = srg_pkg::clamp_screen(screen_height);

    always_comb begin
        w_in = s_tdata[46:38];
        h_in = s_tdata[53:47];
        if ({2'b00, w_in} > srg_pkg::CfgW'(MAX_SPRITE_WIDTH)) begin
            w_in = srg_pkg::SprWW'(MAX_SPRITE_WIDTH);
        end
        if ({4'b0000, h_in} > srg_pkg::CfgW'(MAX_SPRITE_HEIGHT)) begin
            h_in = srg_pkg::SprHW'(MAX_SPRITE_HEIGHT);
        end
    end

    // Clipping against the screen, in signed coordinates.
    always_comb begin
        w_s   = $signed({{(CW-srg_pkg::SprWW){1'b0}}, spr_w_reg});
        h_s   = $signed({{(CW-srg_pkg::SprHW){1'b0}}, spr_h_reg});
        sw_m1 = $signed({{(CW-srg_pkg::CfgW){1'b0}}, sw_c}) - 14'sd1;
        sh_m1 = $signed({{(CW-srg_pkg::CfgW){1'b0}}, sh_c}) - 14'sd1;
        xmin  = $signed({{2{pos_x_reg[11]}}, pos_x_reg}) - $signed({6'b0, ref_x_reg});
        ymin  = $signed({{2{pos_y_reg[11]}}, pos_y_reg}) - $signed({8'b0, ref_y_reg});
        xmax  = xmin + w_s - 14'sd1;
        ymax  = ymin + h_s - 14'sd1;
        sx0   = (xmin < 0) ? -xmin : '0;
        sy0   = (ymin < 0) ? -ymin : '0;
        sx1   = (xmax > sw_m1) ? (w_s - 14'sd1 - (xmax - sw_m1)) : (w_s - 14'sd1);
        sy1   = (ymax > sh_m1) ? (h_s - 14'sd1 - (ymax - sh_m1)) : (h_s - 14'sd1);
        span_s = sx1 - sx0 + 14'sd1;
        rows_s = sy1 - sy0 + 14'sd1;
        vis_c = (spr_w_reg != '0) && (spr_h_reg != '0) && (sx0 <= sx1) && (sy0 <= sy1);
    end

    assign addr_prod = (srg_pkg::AddrW+1)'(y0_reg * sw_c) + (srg_pkg::AddrW+1)'(x0_reg);
    assign off_prod  = (srg_pkg::OffW+1)'(sy0_reg * spr_w_reg) + (srg_pkg::OffW+1)'(sx0_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_x_reg  <= $signed(s_tdata[11:0]);
            pos_y_reg  <= $signed(s_tdata[23:12]);
            ref_x_reg  <= s_tdata[31:24];
            ref_y_reg  <= s_tdata[37:32];
            spr_w_reg  <= w_in;
            spr_h_reg  <= h_in;
            shadow_reg <= s_tuser;
        end
        if (cmd.clip) begin
            x0_reg           <= (xmin < 0) ? '0 : xmin[9:0];
            y0_reg           <= (ymin < 0) ? '0 : ymin[9:0];
            sx0_reg          <= sx0[srg_pkg::SprWW-1:0];
            sy0_reg          <= sy0[5:0];
            latched_span_reg <= span_s[srg_pkg::SprWW-1:0];
        end
        if (cmd.setup) begin
            row_screen_address_reg <= addr_prod[srg_pkg::AddrW-1:0];
            row_sprite_offset_reg  <= off_prod[srg_pkg::OffW-1:0];
        end else if (cmd.emit) begin
            row_screen_address_reg <= row_screen_address_reg
                                      + srg_pkg::AddrW'(sw_c);
            row_sprite_offset_reg  <= row_sprite_offset_reg
                                      + srg_pkg::OffW'(spr_w_reg);
        end
        if (cmd.emit) begin
            m_data_reg <= {5'b00000,
                           latched_span_reg[1:0],
                           latched_span_reg[8:2],
                           row_sprite_offset_reg,
                           row_screen_address_reg};
            m_user_reg <= shadow_reg;
            m_last_reg <= (rows_left_reg == srg_pkg::SprHW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visible_reg   <= 1'b0;
            rows_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clip) begin
                visible_reg   <= vis_c;
                rows_left_reg <= vis_c ? rows_s[srg_pkg::SprHW-1:0] : '0;
            end else if (cmd.emit) begin
                rows_left_reg <= rows_left_reg - srg_pkg::SprHW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.visible  = visible_reg;
    assign status.last_row = (rows_left_reg == srg_pkg::SprHW'(1));
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
